### rtl/core/ptc_pkg.sv
// Shared types and constants for the pressure/temperature compensation block.
// No dependencies; imported by every module under rtl/core.
package ptc_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_TEMP_OFFSET = 3'd0;
  localparam logic [2:0] REG_TEMP_SLOPE  = 3'd1;
  localparam logic [2:0] REG_PRESS_SCALE = 3'd2;
  localparam logic [2:0] REG_PRESS_LOW   = 3'd3;
  localparam logic [2:0] REG_PRESS_HIGH  = 3'd4;

  localparam int RawW   = 20;
  localparam int TempW  = 21;
  localparam int PressW = 20;
  localparam int CfgW   = 64;
  localparam int NumW   = 64;   // Q16 numerator width (wraps like 64-bit math)
  localparam int DivW   = 58;   // divisor width, signed
  localparam int QuoW   = 38;   // quotient bits produced by the divide loop

  localparam logic [PressW-1:0] PA_MAX = 20'hFFFFF;

  // Unpacked calibration words
  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } ptc_cfg_t;

  // Item handed from front end to back end
  typedef struct packed {
    logic signed [NumW-1:0]  num;
    logic signed [DivW-1:0]  dv;
    logic                    dz;
    logic signed [TempW-1:0] temp;
  } ptc_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_MUL1,
    BK_MUL2,
    BK_FIN
  } ptc_bk_state_t;

endpackage

### rtl/core/ptc_front.sv
// Front end: eight-stage pipeline from raw readings to temperature, divisor
// and Q16 dividend. Depends on ptc_pkg.
module ptc_front import ptc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_take,
  input  logic [RawW-1:0]   raw_t,
  input  logic [RawW-1:0]   raw_p,
  input  ptc_cfg_t          cfg,
  output logic              item_valid,
  output ptc_item_t         item
);

  logic [7:0] v_r;

  // stage 1: linear and squared temperature terms
  logic signed [18:0] a1;
  logic signed [16:0] dq1;
  logic signed [34:0] linp_r;
  logic signed [33:0] dqdq_r;
  logic [RawW-1:0]    rp1_r, rp2_r, rp3_r, rp4_r, rp5_r, rp6_r;

  assign a1  = $signed({2'b00, raw_t[19:3]}) - $signed({2'b00, cfg.t1, 1'b0});
  assign dq1 = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, cfg.t1});

  // stage 2: quadratic term product
  logic signed [23:0] lin2_r;
  logic signed [38:0] quadp_r;

  // stage 3: fine temperature
  logic signed [25:0] fine3;
  logic signed [25:0] fine_r;
  assign fine3 = lin2_r + $signed(quadp_r[38:14]);

  // stage 4: offset fine temperature products and temperature
  logic signed [26:0] h4;
  logic signed [53:0] hh4;
  logic signed [42:0] hp5_4, hp2_4;
  logic signed [28:0] t4;
  logic signed [53:0] hh_r;
  logic signed [42:0] hp5_r, hp2_r;
  logic signed [TempW-1:0] temp4_r, temp5_r, temp6_r, temp7_r;

  assign h4    = fine_r - 27'sd128000;
  assign hh4   = h4 * h4;
  assign hp5_4 = h4 * cfg.p5;
  assign hp2_4 = h4 * cfg.p2;
  assign t4    = fine_r * 29'sd5 + 29'sd128;

  // stage 5: wide products, kept modulo 2^64; linear terms wait alongside
  logic signed [69:0] hh6_5, p3hh_5;
  logic signed [63:0] hh6_r, p3hh_r;
  logic signed [42:0] hp5d_r, hp2d_r;
  assign hh6_5  = hh_r * cfg.p6;
  assign p3hh_5 = hh_r * cfg.p3;

  // stage 6: offset term and divisor base
  logic signed [63:0] hh6s6, bqs6;
  logic [63:0] bqa6, bq6, xs6;
  logic [63:0] bq_r;
  logic signed [40:0] x_r;
  assign hh6s6 = hh6_r >>> 1;
  assign bqa6  = hh6s6 + {{5{hp5d_r[42]}}, hp5d_r, 16'b0};
  assign bqs6  = $signed(bqa6) >>> 2;
  assign bq6   = bqs6 + {{16{cfg.p4[15]}}, cfg.p4, 32'b0};
  assign xs6   = 64'h0080_0000_0000_0000 + p3hh_r + {hp2d_r[42], hp2d_r, 20'b0};

  // stage 7: divisor and numerator base
  logic [20:0]            rpc7;
  logic signed [52:0]     wq7;
  logic signed [DivW-1:0] dv7;
  logic signed [52:0]     wq_r;
  logic signed [DivW-1:0] dv_r;
  assign rpc7 = 21'h100000 - {1'b0, rp6_r};
  assign wq7  = $signed({16'b0, rpc7, 16'b0}) - $signed(bq_r[63:12]);
  assign dv7  = $signed({1'b0, cfg.p1}) * x_r;

  // stage 8: scale numerator by 6250 (wraps at 64 bits)
  logic signed [65:0] np8;
  assign np8 = wq_r * $signed(14'd6250);

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[6:0], in_take};
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    linp_r  <= a1 * cfg.t2;
    dqdq_r  <= dq1 * dq1;
    rp1_r   <= raw_p;
    lin2_r  <= linp_r[34:11];
    quadp_r <= $signed({1'b0, dqdq_r[33:12]}) * cfg.t3;
    rp2_r   <= rp1_r;
    fine_r  <= fine3;
    rp3_r   <= rp2_r;
    hh_r    <= hh4;
    hp5_r   <= hp5_4;
    hp2_r   <= hp2_4;
    temp4_r <= t4[28:8];
    rp4_r   <= rp3_r;
    hh6_r   <= hh6_5[63:0];
    p3hh_r  <= p3hh_5[63:0];
    hp5d_r  <= hp5_r;
    hp2d_r  <= hp2_r;
    temp5_r <= temp4_r;
    rp5_r   <= rp4_r;
    bq_r    <= bq6;
    x_r     <= $signed(xs6[63:23]);
    temp6_r <= temp5_r;
    rp6_r   <= rp5_r;
    wq_r    <= wq7;
    dv_r    <= dv7;
    temp7_r <= temp6_r;
    item.num  <= np8[63:0];
    item.dv   <= dv_r;
    item.dz   <= (dv_r == '0);
    item.temp <= temp7_r;
  end

  assign item_valid = v_r[7];

endmodule

### rtl/core/ptc_queue.sv
// Small FIFO of items between the front and back ends.
// Depends on ptc_pkg for the item type.
module ptc_queue import ptc_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ptc_item_t wr_item,
  input  logic      pop,
  output logic      not_empty,
  output ptc_item_t rd_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ptc_item_t         entry_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [AW:0]       count_r;

  // pointer and count update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_item;
    end
  end

  assign not_empty = (count_r != '0);
  assign rd_item   = entry_r[rd_ptr_r];

endmodule

### rtl/core/ptc_back.sv
// Back end: radix-2 divide loop and quadratic correction of the quotient.
// Depends on ptc_pkg.
module ptc_back import ptc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     have_item,
  input  ptc_item_t                item,
  input  ptc_cfg_t                 cfg,
  output logic                     pop,
  output logic                     res_valid,
  output logic signed [TempW-1:0]  res_temp,
  output logic [PressW-1:0]        res_pa,
  output logic                     res_dz
);

  ptc_bk_state_t state_r, state_nxt;
  logic [5:0]    cnt_r;

  logic [DivW-1:0]        ud_r;
  logic [DivW-1:0]        pr_r;
  logic [QuoW-1:0]        nb_r;
  logic [QuoW:0]          qm_r;
  logic                   neg_r, dz_r;
  logic signed [TempW-1:0] temp_r;

  // item classification on load
  logic [NumW-1:0] un_l;
  logic [DivW-1:0] ud_l;
  logic            ovf_l;
  assign un_l  = item.num[NumW-1] ? NumW'(-item.num) : NumW'(item.num);
  assign ud_l  = item.dv[DivW-1] ? DivW'(-item.dv) : DivW'(item.dv);
  assign ovf_l = ({16'b0, un_l[63:22]} >= ud_l);

  // one quotient bit per cycle
  logic [DivW:0]   pr2;
  logic            ge;
  logic [DivW:0]   prd;
  assign pr2 = {pr_r, nb_r[QuoW-1]};
  assign ge  = (pr2 >= {1'b0, ud_r});
  assign prd = ge ? pr2 - {1'b0, ud_r} : pr2;

  // correction products
  logic signed [39:0] qs;
  logic signed [63:0] sqp_r;
  logic signed [55:0] qp8_r;
  logic signed [39:0] q_r;
  logic signed [62:0] s9_r;
  assign qs = neg_r ? -$signed({1'b0, qm_r}) : $signed({1'b0, qm_r});

  // final sum, rounding and limits
  logic signed [63:0] c9, c8, c7, corr, rq;
  logic [63:0]        rnd;
  logic [PressW-1:0]  pa_f;
  assign c9   = s9_r >>> 16;
  assign c8   = qp8_r >>> 15;
  assign c7   = cfg.p7 <<< 16;
  assign corr = c9 + c8 + c7;
  assign rq   = q_r + (corr >>> 4);
  assign rnd  = 64'(rq) + 64'd32768;

  always_comb begin
    if (dz_r || rq[63]) begin
      pa_f = '0;
    end else if (rnd[63:16] > {28'b0, PA_MAX}) begin
      pa_f = PA_MAX;
    end else begin
      pa_f = rnd[35:16];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (have_item) begin
          if (item.dz) state_nxt = BK_FIN;
          else if (ovf_l) state_nxt = BK_MUL1;
          else state_nxt = BK_DIV;
        end
      end
      BK_DIV:  if (cnt_r == 6'(QuoW - 1)) state_nxt = BK_MUL1;
      BK_MUL1: state_nxt = BK_MUL2;
      BK_MUL2: state_nxt = BK_FIN;
      BK_FIN:  state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop = 1'b0;
    case (state_r)
      BK_IDLE: pop = have_item;
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      res_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      res_valid <= (state_r == BK_FIN);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        ud_r   <= ud_l;
        pr_r   <= {16'b0, un_l[63:22]};
        nb_r   <= {un_l[21:0], 16'b0};
        qm_r   <= ovf_l ? {1'b1, {QuoW{1'b0}}} : '0;
        neg_r  <= item.num[NumW-1] ^ item.dv[DivW-1];
        dz_r   <= item.dz;
        temp_r <= item.temp;
        cnt_r  <= '0;
      end
      BK_DIV: begin
        pr_r  <= prd[DivW-1:0];
        nb_r  <= {nb_r[QuoW-2:0], 1'b0};
        qm_r  <= {qm_r[QuoW-1:0], ge};
        cnt_r <= cnt_r + 6'd1;
      end
      BK_MUL1: begin
        q_r   <= qs;
        sqp_r <= $signed(qs[39:8]) * $signed(qs[39:8]);
        qp8_r <= qs * cfg.p8;
      end
      BK_MUL2: begin
        s9_r <= $signed({1'b0, sqp_r[60:15]}) * cfg.p9;
      end
      BK_FIN: begin
        res_temp <= temp_r;
        res_pa   <= pa_f;
        res_dz   <= dz_r;
      end
      default: ;
    endcase
  end

endmodule

### rtl/core/pressure_temperature_compensate.sv
// Top level of the barometric compensation block: configuration registers,
// item credit count, front pipeline, queue and back end. Depends on ptc_pkg.
//
// An item (raw temperature and pressure) is taken when start is high and busy
// low. It runs through an 8-stage front pipeline into a QUEUE_DEPTH-entry
// queue; the back end then divides and corrects one item at a time. Each item
// runs through the back end's 38-step one-bit-per-cycle divide loop, then the
// MUL1, MUL2 and FIN states; a saturating quotient skips the loop and a zero
// divisor goes straight to FIN. busy is high while QUEUE_DEPTH items are
// accepted but not yet in the back end. Each result appears for one cycle with
// out_valid and must be taken then; results leave in input order.
module pressure_temperature_compensate import ptc_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [RawW-1:0]          in_raw_temperature,
  input  logic [RawW-1:0]          in_raw_pressure,
  output logic                     out_valid,
  output logic signed [TempW-1:0]  out_temperature_centi,
  output logic [PressW-1:0]        out_pressure_pa,
  output logic                     out_divisor_zero,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [CfgW-1:0]          cfg_wdata
);

  localparam int OW = $clog2(QUEUE_DEPTH + 1);

  logic [15:0] t_off_r;
  logic [31:0] t_slope_r;
  logic [15:0] p_scale_r;
  logic [63:0] p_low_r, p_high_r;
  ptc_cfg_t    cfg;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_off_r   <= '0;
      t_slope_r <= '0;
      p_scale_r <= '0;
      p_low_r   <= '0;
      p_high_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEMP_OFFSET: t_off_r   <= cfg_wdata[15:0];
        REG_TEMP_SLOPE:  t_slope_r <= cfg_wdata[31:0];
        REG_PRESS_SCALE: p_scale_r <= cfg_wdata[15:0];
        REG_PRESS_LOW:   p_low_r   <= cfg_wdata;
        REG_PRESS_HIGH:  p_high_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.t1 = t_off_r;
  assign cfg.t2 = t_slope_r[15:0];
  assign cfg.t3 = t_slope_r[31:16];
  assign cfg.p1 = p_scale_r;
  assign cfg.p2 = p_low_r[15:0];
  assign cfg.p3 = p_low_r[31:16];
  assign cfg.p4 = p_low_r[47:32];
  assign cfg.p5 = p_low_r[63:48];
  assign cfg.p6 = p_high_r[15:0];
  assign cfg.p7 = p_high_r[31:16];
  assign cfg.p8 = p_high_r[47:32];
  assign cfg.p9 = p_high_r[63:48];

  // credits: items accepted but not yet in the back end
  logic          take, pop, q_push, q_ne;
  logic [OW-1:0] occ_r;
  ptc_item_t     f_item, q_item;

  assign take = start & ~busy;
  assign busy = (occ_r == OW'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_r + OW'(take) - OW'(pop);
    end
  end

  ptc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_take    (take),
    .raw_t      (in_raw_temperature),
    .raw_p      (in_raw_pressure),
    .cfg        (cfg),
    .item_valid (q_push),
    .item       (f_item)
  );

  ptc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_item   (f_item),
    .pop       (pop),
    .not_empty (q_ne),
    .rd_item   (q_item)
  );

  ptc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .have_item (q_ne),
    .item      (q_item),
    .cfg       (cfg),
    .pop       (pop),
    .res_valid (out_valid),
    .res_temp  (out_temperature_centi),
    .res_pa    (out_pressure_pa),
    .res_dz    (out_divisor_zero)
  );

endmodule
